/* rtl/dram_bank_row_latency_assert.svh */
// Assertion macros used by the RTL that checks itself.
// Clocked on i_clk, disabled while i_rst_n is low.
`ifndef DRAM_BANK_ROW_LATENCY_ASSERT_SVH
`define DRAM_BANK_ROW_LATENCY_ASSERT_SVH

`ifndef SYNTHESIS
// Check that cond holds at every clock edge.
`define DBRL_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("dbrl assertion failed");
// Check that cons holds in the cycle after ante.
`define DBRL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dbrl assertion failed");
`else
`define DBRL_ASSERT_ALWAYS(label, cond)
`define DBRL_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/dbrl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dbrl_pkg;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_CMD_ERR  = 2'd1,
        STATUS_ADDR_ERR = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ROW_NONE  = 2'd0,
        ROW_FIRST = 2'd1,
        ROW_HIT   = 2'd2,
        ROW_MISS  = 2'd3
    } t_row_case;

    localparam int unsigned BANK_LSB   = 13;
    localparam int unsigned ROW_LSB    = 15;
    localparam int unsigned WR_SHIFT   = 3;
    localparam int unsigned RD_SHIFT   = 2;
    localparam int unsigned LIMIT_BITS = 33;
    localparam int unsigned CYC_BITS   = 15;
    localparam logic [CYC_BITS-1:0] CYCLES_MAX = 15'h7FFF;

    localparam int unsigned CFG_ADDR_BITS = 5;
    localparam int unsigned CFG_DATA_BITS = 64;
    localparam logic [1:0] REG_CAS   = 2'd0;
    localparam logic [1:0] REG_RCD   = 2'd1;
    localparam logic [1:0] REG_RP    = 2'd2;
    localparam logic [1:0] REG_LIMIT = 2'd3;

    typedef struct packed {
        logic [3:0]            cas;
        logic [3:0]            rcd;
        logic [3:0]            rp;
        logic [LIMIT_BITS-1:0] limit;
    } t_timing;

    typedef struct packed {
        logic open;
        logic hit;
    } t_bank_look;

    typedef struct packed {
        logic [CYC_BITS-1:0] cycles;
        t_status             status;
        t_row_case           row_case;
        logic                update;
    } t_cost_res;

endpackage

`default_nettype wire

/* rtl/dbrl_cost.sv */
`timescale 1ns / 1ps
`default_nettype none

module dbrl_cost #(
    parameter int unsigned ADDRESS_BITS = 32,
    parameter int unsigned LENGTH_BITS  = 16
) (
    input  wire logic [1:0]              i_kind,
    input  wire logic [ADDRESS_BITS-1:0] i_address,
    input  wire logic [LENGTH_BITS-1:0]  i_length,
    input  wire dbrl_pkg::t_timing       i_timing,
    input  wire dbrl_pkg::t_bank_look    i_look,
    output dbrl_pkg::t_cost_res          o_res
);
    import dbrl_pkg::*;

    localparam int unsigned CMPW = (ADDRESS_BITS > LIMIT_BITS) ? ADDRESS_BITS : LIMIT_BITS;
    localparam int unsigned CW   = LENGTH_BITS + 2;
    localparam int unsigned SW   = (CW > CYC_BITS + 1) ? CW : CYC_BITS + 1;

    logic          addr_err;
    logic [CW-1:0] wr_sum;
    logic [CW-1:0] rd_base;
    logic [CW-1:0] rd_act;
    logic [CW-1:0] rd_miss;
    logic [CW-1:0] sel_sum;
    logic [SW-1:0] sel_ext;

    assign addr_err = CMPW'(i_address) >= CMPW'(i_timing.limit);

    // Write: length/8 + length%8; read: length/4 + length%4 + CAS.
    assign wr_sum  = CW'(i_length >> WR_SHIFT) + CW'(i_length[WR_SHIFT-1:0]);
    assign rd_base = CW'(i_length >> RD_SHIFT) + CW'(i_length[RD_SHIFT-1:0])
                   + CW'(i_timing.cas);
    assign rd_act  = rd_base + CW'(i_timing.rcd);
    assign rd_miss = rd_act + CW'(i_timing.rp);

    always_comb begin
        o_res.status   = STATUS_OK;
        o_res.row_case = ROW_NONE;
        o_res.update   = 1'b0;
        sel_sum        = '0;
        if (addr_err) begin
            o_res.status = STATUS_ADDR_ERR;
        end else begin
            case (i_kind)
                KIND_WRITE: begin
                    sel_sum      = wr_sum;
                    o_res.update = 1'b1;
                end
                KIND_READ: begin
                    o_res.update = 1'b1;
                    if (!i_look.open) begin
                        sel_sum        = rd_act;
                        o_res.row_case = ROW_FIRST;
                    end else if (i_look.hit) begin
                        sel_sum        = rd_base;
                        o_res.row_case = ROW_HIT;
                    end else begin
                        sel_sum        = rd_miss;
                        o_res.row_case = ROW_MISS;
                    end
                end
                default: begin
                    o_res.status = STATUS_CMD_ERR;
                end
            endcase
        end
        // Saturate at the largest count the result field holds.
        sel_ext = SW'(sel_sum);
        if (sel_ext > SW'(CYCLES_MAX)) begin
            o_res.cycles = CYCLES_MAX;
        end else begin
            o_res.cycles = sel_ext[CYC_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

/* rtl/dram_bank_row_latency.sv */
// Each request is registered in the input stage, then its result in the result
// stage. Throughput: one request per cycle unless the result side stalls; the
// bank table read, row compare and update happen together as the request moves on.
// Reset (synchronous, active low): empty pipeline, all banks closed, timing
// registers at CAS 2, RAS-to-CAS 2, precharge 3, memory limit 0x10000.
`timescale 1ns / 1ps
`default_nettype none

`include "dram_bank_row_latency_assert.svh"

module dram_bank_row_latency #(
    parameter int unsigned ADDRESS_BITS = 32,
    parameter int unsigned LENGTH_BITS  = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // request channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [1:0]                         i_kind,
    input  wire logic [ADDRESS_BITS-1:0]            i_address,
    input  wire logic [LENGTH_BITS-1:0]             i_length,
    // result channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [dbrl_pkg::CYC_BITS-1:0]           o_cycles,
    output logic [1:0]                              o_status,
    output logic [1:0]                              o_row_case,
    // configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [dbrl_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [dbrl_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [dbrl_pkg::CFG_DATA_BITS-1:0]      prdata,
    output logic                                    pready
);
    import dbrl_pkg::*;

    localparam int unsigned ROW_BITS = ADDRESS_BITS - ROW_LSB;

    // Timing registers.
    t_timing r_timing;
    logic    cfg_wr;
    logic [1:0] cfg_idx;

    // Input stage: holds the request being costed.
    logic                    r_s1_valid;
    logic [1:0]              r_kind;
    logic [ADDRESS_BITS-1:0] r_addr;
    logic [LENGTH_BITS-1:0]  r_len;

    // Result stage.
    logic                r_out_valid;
    logic [CYC_BITS-1:0] r_cycles;
    t_status             r_status;
    t_row_case           r_row_case;

    // Bank table: open flags reset, rows only read while the bank is open.
    logic [3:0]          r_bank_open;
    logic [ROW_BITS-1:0] r_bank_row [4];

    logic                s1_adv;
    logic                s1_fire;
    logic [1:0]          bank;
    logic [ROW_BITS-1:0] row;
    t_bank_look          look;
    t_cost_res           res;
    logic                out_err_clean;

    // The result stage frees up when empty or when its result is taken.
    assign s1_adv     = !r_out_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && s1_adv;
    assign o_in_ready = !r_s1_valid || s1_adv;

    // Bank from address bits 14:13, row from bit 15 up.
    assign bank = r_addr[BANK_LSB+1:BANK_LSB];
    assign row  = r_addr[ADDRESS_BITS-1:ROW_LSB];

    assign look.open = r_bank_open[bank];
    assign look.hit  = (r_bank_row[bank] == row);

    dbrl_cost #(
        .ADDRESS_BITS(ADDRESS_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_cost (
        .i_kind   (r_kind),
        .i_address(r_addr),
        .i_length (r_len),
        .i_timing (r_timing),
        .i_look   (look),
        .o_res    (res)
    );

    // Configuration: register i at byte address 8*i, write on the access phase.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[CFG_ADDR_BITS-1:CFG_ADDR_BITS-2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.cas   <= 4'd2;
            r_timing.rcd   <= 4'd2;
            r_timing.rp    <= 4'd3;
            r_timing.limit <= LIMIT_BITS'(65536);
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_CAS:   r_timing.cas   <= pwdata[3:0];
                REG_RCD:   r_timing.rcd   <= pwdata[3:0];
                REG_RP:    r_timing.rp    <= pwdata[3:0];
                REG_LIMIT: r_timing.limit <= pwdata[LIMIT_BITS-1:0];
                default:   r_timing       <= r_timing;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_CAS:   prdata = CFG_DATA_BITS'(r_timing.cas);
            REG_RCD:   prdata = CFG_DATA_BITS'(r_timing.rcd);
            REG_RP:    prdata = CFG_DATA_BITS'(r_timing.rp);
            REG_LIMIT: prdata = CFG_DATA_BITS'(r_timing.limit);
            default:   prdata = '0;
        endcase
    end

    // Input stage: load a new request whenever the stage is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_kind <= i_kind;
            r_addr <= i_address;
            r_len  <= i_length;
        end
    end

    // Result stage: advance when the slot frees, hold while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_cycles   <= res.cycles;
            r_status   <= res.status;
            r_row_case <= res.row_case;
        end
    end

    // Bank table update in the same cycle the request moves to the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_open <= '0;
        end else if (s1_fire && res.update) begin
            r_bank_open[bank] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && res.update) begin
            r_bank_row[bank] <= row;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cycles    = r_cycles;
    assign o_status    = r_status;
    assign o_row_case  = r_row_case;

    assign out_err_clean = (r_status == STATUS_OK)
                         || (r_cycles == '0 && r_row_case == ROW_NONE);

    // Errors cost nothing and carry no row case.
    `DBRL_ASSERT_ALWAYS(a_err_zero, !r_out_valid || out_err_clean)
    // A request leaving the input stage always shows up as a result.
    `DBRL_ASSERT_NEXT(a_fire_result, s1_fire, r_out_valid)
    // An accepted write or read leaves its bank open.
    `DBRL_ASSERT_NEXT(a_bank_opened, s1_fire && res.update, r_bank_open[$past(bank)])

endmodule

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import dbrl_pkg::*;

    // Command codes that the block must reject; only write and read are defined.
    localparam logic [1:0] KIND_BAD_2 = 2'd2;
    localparam logic [1:0] KIND_BAD_3 = 2'd3;

    // Largest legal memory limit: the whole 32-bit address space is in range.
    localparam logic [LIMIT_BITS-1:0] LIMIT_FULL  = 33'h1_0000_0000;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 33'h0_0001_0000;

    // Cycles to let pass after the last result before touching the timing
    // registers or ending the run.
    localparam int SETTLE_CYCLES = 6;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [CYC_BITS-1:0] cycles;
        t_status             status;
        t_row_case           row_case;
    } t_latency;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [1:0]               i_kind = 2'd0;
    logic [31:0]              i_address = '0;
    logic [15:0]              i_length = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic [CYC_BITS-1:0]      o_cycles;
    logic [1:0]               o_status;
    logic [1:0]               o_row_case;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr = '0;
    logic [CFG_DATA_BITS-1:0] pwdata = '0;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    dram_bank_row_latency dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_address   (i_address),
        .i_length    (i_length),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cycles    (o_cycles),
        .o_status    (o_status),
        .o_row_case  (o_row_case),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Our own copy of the timing registers and the open-row table.
    logic [3:0]            tim_cas;
    logic [3:0]            tim_rcd;
    logic [3:0]            tim_rp;
    logic [LIMIT_BITS-1:0] tim_limit;
    logic                  row_is_open [4];
    logic [16:0]           open_row    [4];

    t_latency expected_costs [$];
    t_latency popped_cost;
    int       cost_errors = 0;

    // Idle rates in percent for each side, and the receiver hold-off request.
    int send_idle_pct = 31;
    int recv_idle_pct = 61;
    int hold_request  = 0;
    int hold_left     = 0;

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs a handshake.
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Work out the cost of one accepted request and advance the bank table.
    function automatic t_latency predict_cost(logic [1:0] kind, logic [31:0] addr,
                                              logic [15:0] len);
        t_latency    res;
        logic [1:0]  bank;
        logic [16:0] row;
        int unsigned cost;
        bank = addr[BANK_LSB+1:BANK_LSB];
        row  = addr[31:ROW_LSB];
        cost = 0;
        res.status   = STATUS_OK;
        res.row_case = ROW_NONE;
        // The range check wins over the command check.
        if ({1'b0, addr} >= tim_limit) begin
            res.status = STATUS_ADDR_ERR;
        end else if (kind == KIND_WRITE) begin
            // Floor plus remainder, deliberately not a ceiling.
            cost = 32'(len >> 3) + 32'(len[2:0]);
            row_is_open[bank] = 1'b1;
            open_row[bank]    = row;
        end else if (kind == KIND_READ) begin
            cost = 32'(len >> 2) + 32'(len[1:0]) + 32'(tim_cas);
            if (!row_is_open[bank]) begin
                cost += 32'(tim_rcd);
                res.row_case = ROW_FIRST;
            end else if (open_row[bank] == row) begin
                res.row_case = ROW_HIT;
            end else begin
                cost += 32'(tim_rcd) + 32'(tim_rp);
                res.row_case = ROW_MISS;
            end
            row_is_open[bank] = 1'b1;
            open_row[bank]    = row;
        end else begin
            res.status = STATUS_CMD_ERR;
        end
        if (cost > 32'(CYCLES_MAX)) begin
            cost = 32'(CYCLES_MAX);
        end
        res.cycles = cost[CYC_BITS-1:0];
        return res;
    endfunction

    // Receiver: random back-pressure, or a long counted hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left   = hold_left - 1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Result checker. Everything the block drives settles after the rising edge,
    // so sample at the falling edge: a handshake seen here completes at the
    // next rising edge.
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_costs.size() == 0) begin
                cost_errors++;
                if (cost_errors <= MAX_REPORTS) begin
                    $display("%0t: result with no request pending: %s%0d %s%0d %s%0d",
                             $realtime, "cycles=", o_cycles, "status=", o_status,
                             "row=", o_row_case);
                end
            end else begin
                popped_cost = expected_costs.pop_front();
                if (o_cycles !== popped_cost.cycles || o_status !== popped_cost.status ||
                    o_row_case !== popped_cost.row_case) begin
                    cost_errors++;
                    if (cost_errors <= MAX_REPORTS) begin
                        $display("%0t: cost mismatch: exp cycles=%0d status=%0d row=%0d,",
                                 $realtime, popped_cost.cycles, popped_cost.status,
                                 popped_cost.row_case);
                        $display("    got cycles=%0d status=%0d row=%0d",
                                 o_cycles, o_status, o_row_case);
                    end
                end
            end
        end
    end

    // Offer one request, idling first at the sender's rate. Returns at the
    // rising edge where the request is taken, with valid still high.
    task automatic send_request(input logic [1:0] kind, input logic [31:0] addr,
                                input logic [15:0] len);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_address  <= addr;
        i_length   <= len;
        @(negedge i_clk);
        while (!o_in_ready) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
        expected_costs.push_back(predict_cost(kind, addr, len));
    endtask

    // Drop valid and wait for the pipeline to empty.
    task automatic drain_requests();
        i_in_valid <= 1'b0;
        while (expected_costs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One APB write: setup cycle, then access cycle. Bits above the register
    // width carry random junk that the block must drop.
    task automatic apb_write(input logic [1:0] reg_index, input logic [LIMIT_BITS-1:0] value);
        logic [CFG_DATA_BITS-1:0] wdata;
        wdata = {$urandom(), $urandom()};
        case (reg_index)
            REG_CAS: begin
                wdata[3:0] = value[3:0];
                tim_cas    = value[3:0];
            end
            REG_RCD: begin
                wdata[3:0] = value[3:0];
                tim_rcd    = value[3:0];
            end
            REG_RP: begin
                wdata[3:0] = value[3:0];
                tim_rp     = value[3:0];
            end
            default: begin
                wdata[LIMIT_BITS-1:0] = value;
                tim_limit             = value;
            end
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 3'b000};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_timing(input logic [3:0] cas, input logic [3:0] rcd,
                              input logic [3:0] rp, input logic [LIMIT_BITS-1:0] limit);
        drain_requests();
        apb_write(REG_CAS, {29'd0, cas});
        apb_write(REG_RCD, {29'd0, rcd});
        apb_write(REG_RP, {29'd0, rp});
        apb_write(REG_LIMIT, limit);
    endtask

    // Mostly well-formed traffic: addresses inside the limit, rows drawn from a
    // small pool so hits and misses are common. The rest is wild addresses,
    // bad commands and extreme lengths.
    task automatic random_request();
        logic [1:0]  kind;
        logic [1:0]  bank;
        logic [31:0] addr;
        logic [15:0] len;
        int unsigned row_top;
        int unsigned row;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            kind = KIND_WRITE;
        end else if (pick < 90) begin
            kind = KIND_READ;
        end else if (pick < 95) begin
            kind = KIND_BAD_2;
        end else begin
            kind = KIND_BAD_3;
        end
        row_top = (tim_limit == 0) ? 0 : int'((tim_limit - 1) >> ROW_LSB);
        if (row_top > 17'h1FFFF) begin
            row_top = 17'h1FFFF;
        end
        if ($urandom_range(99) < 80) begin
            row = $urandom_range(0, (row_top < 3) ? row_top : 3);
        end else begin
            row = $urandom_range(0, row_top);
        end
        bank = 2'($urandom_range(3));
        addr = {row[16:0], bank, 13'($urandom_range(0, 8191))};
        if ($urandom_range(99) < 10) begin
            addr = $urandom();
        end
        pick = $urandom_range(99);
        if (pick < 50) begin
            len = 16'($urandom_range(0, 64));
        end else if (pick < 90) begin
            len = 16'($urandom_range(0, 65535));
        end else begin
            len = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        end
        send_request(kind, addr, len);
    endtask

    task automatic random_timing();
        logic [LIMIT_BITS-1:0] limit;
        int                    pick;
        pick = $urandom_range(99);
        if (pick < 50) begin
            limit = LIMIT_FULL;
        end else if (pick < 75) begin
            limit = LIMIT_RESET;
        end else begin
            limit = {1'b0, $urandom()};
        end
        set_timing(4'($urandom_range(15)), 4'($urandom_range(15)),
                   4'($urandom_range(15)), limit);
    endtask

    // Reset timing: first opens, hits, misses, both error kinds, length extremes.
    task automatic test_directed_cases();
        send_request(KIND_WRITE, 32'h0000_0000, 16'h0000);  // open bank 0, row 0
        send_request(KIND_READ,  32'h0000_0000, 16'hFFFF);  // row hit, longest read
        send_request(KIND_READ,  32'h0000_2000, 16'h0000);  // first open of bank 1
        send_request(KIND_READ,  32'h0000_A000, 16'h0007);  // row miss on bank 1
        send_request(KIND_WRITE, 32'h0000_FFFF, 16'hFFFF);  // last in-range byte
        send_request(KIND_READ,  32'h0001_0000, 16'h0010);  // exactly at the limit
        send_request(KIND_BAD_2, 32'h0000_0100, 16'h0020);
        send_request(KIND_BAD_3, 32'h0000_4000, 16'hFFFF);
        send_request(KIND_BAD_3, 32'hFFFF_FFFF, 16'h0001);  // range beats command
        send_request(KIND_READ,  32'h0000_6000, 16'h0003);  // bank 3: row 1 to row 0
        send_request(KIND_WRITE, 32'h0000_4000, 16'h0008);
        send_request(KIND_WRITE, 32'h0000_4000, 16'h000F);
        send_request(KIND_READ,  32'h0000_5FFF, 16'h0005);  // hit on bank 2
        send_request(KIND_READ,  32'h0000_C000, 16'h0004);  // miss on bank 2
        send_request(KIND_READ,  32'h0000_C000, 16'h0000);  // hit with zero length
        send_request(KIND_WRITE, 32'h0000_0000, 16'h0000);
        drain_requests();
    endtask

    // Timing registers at both ends of their range.
    task automatic test_register_extremes();
        set_timing(4'd0, 4'd0, 4'd0, '0);                   // every address rejected
        repeat (20) random_request();
        set_timing(4'd15, 4'd15, 4'd15, LIMIT_FULL);
        send_request(KIND_WRITE, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(KIND_READ,  32'h7FFF_E000, 16'hFFFF);  // worst-case miss
        send_request(KIND_READ,  32'hFFFF_FFFF, 16'hFFFF);
        send_request(KIND_READ,  32'hFFFF_FFFF, 16'hFFFF);
        repeat (40) random_request();
        set_timing(4'd2, 4'd2, 4'd3, LIMIT_RESET);
        repeat (30) random_request();
        drain_requests();
    endtask

    // Hold the result side off for a long stretch and keep offering requests,
    // so the pipeline fills and the block must drop its ready.
    task automatic test_backpressure();
        send_idle_pct = 0;
        @(negedge i_clk);
        hold_request = 200;
        @(posedge i_clk);
        repeat (40) random_request();
        drain_requests();
        send_idle_pct = 31;
    endtask

    // Bulk random traffic under the three idle patterns, retiming in between.
    task automatic test_random_traffic();
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_idle_pct = 31;
                    recv_idle_pct = 61;
                end
                1: begin
                    send_idle_pct = 61;
                    recv_idle_pct = 31;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (5) begin
                random_timing();
                repeat (100) random_request();
            end
        end
        drain_requests();
    endtask

    initial begin
        tim_cas   = 4'd2;
        tim_rcd   = 4'd2;
        tim_rp    = 4'd3;
        tim_limit = LIMIT_RESET;
        for (int b = 0; b < 4; b++) begin
            row_is_open[b] = 1'b0;
            open_row[b]    = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();

        if (cost_errors == 0 && expected_costs.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
